@@ sv/cvl_pkg.sv @@
// shared types and codes of the compacting value list
`default_nettype none

package cvl_pkg;

  // request commands
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MISSING   = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  localparam int DATA_W  = 32;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;

  // per-cycle controls broadcast along the row of cells
  typedef struct packed {
    logic capture;
    logic append;
    logic remove;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ sv/cvl_if.sv @@
// request and result channel interfaces of the compacting value list
`default_nettype none

interface cvl_in_if;
  import cvl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, command, value, position, input ready);
  modport sink   (input valid, command, value, position, output ready);
endinterface

interface cvl_out_if;
  import cvl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] read_value;
  logic [COUNT_W-1:0]       entry_count;

  modport source (output valid, status, read_value, entry_count, input ready);
  modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

`default_nettype wire

@@ sv/compacting_value_list.sv @@
// top level of the compacting value list: control, count and row of cells
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------
//  in_chan  | in  | valid/ready        | command, value, position
//  out_chan | out | valid/ready        | status, read_value, entry_count
//
// each request runs a compare step, which registers every cell's compare and
// read hit, then an update step, which runs the first-match chain, shifts or
// appends and loads the output register; the cell compare register parts them.
// reset clears the count and the handshake state; entries need no clearing.
// while a result waits in the output register the next request is still taken,
// and its update waits until that result is taken.
`default_nettype none

module compacting_value_list import cvl_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  cvl_in_if.sink    in_chan,
  cvl_out_if.source out_chan
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic                     busy_r;
  cmd_t                     cmd_r;
  logic signed [DATA_W-1:0] val_r;
  logic [POS_W-1:0]         pos_r;
  logic [CW-1:0]            count_r;
  logic [CW-1:0]            count_nxt;
  logic                     out_valid_r;
  status_t                  status_r;
  status_t                  status_nxt;
  logic signed [DATA_W-1:0] rdval_r;
  logic signed [DATA_W-1:0] rdval_nxt;

  logic      accept;
  logic      finish;
  logic      found;
  cell_ctl_t ctl;

  logic                     seen  [CAPACITY+1];
  logic signed [DATA_W-1:0] rd    [CAPACITY+1];
  logic signed [DATA_W-1:0] entry [CAPACITY];

  // handshake
  assign in_chan.ready = !busy_r;
  assign accept        = in_chan.valid && in_chan.ready;
  assign finish        = busy_r && (!out_valid_r || out_chan.ready);

  assign ctl.capture = accept;
  assign ctl.append  = finish && (cmd_r == CMD_INSERT);
  assign ctl.remove  = finish && (cmd_r == CMD_REMOVE);

  // row of cells
  assign seen[0] = 1'b0;
  assign rd[0]   = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] nxt;
    if (i == CAPACITY - 1) begin : g_last
      assign nxt = entry[i];
    end else begin : g_mid
      assign nxt = entry[i+1];
    end

    cvl_cell #(
      .IDX  (i),
      .CW   (CW),
      .CMPW (CMPW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .cmp_value  (in_chan.value),
      .rd_pos     (CMPW'(in_chan.position)),
      .count      (count_r),
      .app_value  (val_r),
      .next_entry (nxt),
      .seen_in    (seen[i]),
      .seen_out   (seen[i+1]),
      .rd_in      (rd[i]),
      .rd_out     (rd[i+1]),
      .entry_o    (entry[i])
    );
  end

  assign found = seen[CAPACITY];

  // result and new count
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    rdval_nxt  = '0;
    case (cmd_r)
      CMD_INSERT: begin
        if (count_r >= CW'(CAPACITY)) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      CMD_REMOVE: begin
        if (found) begin
          count_nxt = count_r - CW'(1);
        end else begin
          status_nxt = ST_MISSING;
        end
      end
      CMD_SEARCH: begin
        if (!found) begin
          status_nxt = ST_MISSING;
        end
      end
      CMD_READ: begin
        if (CMPW'(pos_r) >= CMPW'(count_r)) begin
          status_nxt = ST_BAD_INDEX;
        end else begin
          rdval_nxt = rd[CAPACITY];
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end else if (finish) begin
        busy_r <= 1'b0;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
        count_r     <= count_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_t'(in_chan.command);
      val_r <= in_chan.value;
      pos_r <= in_chan.position;
    end
    if (finish) begin
      status_r <= status_nxt;
      rdval_r  <= rdval_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = status_r;
  assign out_chan.read_value  = rdval_r;
  assign out_chan.entry_count = COUNT_W'(count_r);

  // count never exceeds capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // count moves only when a request completes
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !finish |=> $stable(count_r))
    else $error("entry count changed without a completing request");

  // a successful remove drops the count by exactly one
  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && (cmd_r == CMD_REMOVE) && found) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("remove did not drop the count by one");

  // a new result appears only after a request was in work
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r))
    else $error("result without a request in work");

endmodule

`default_nettype wire

@@ sv/cvl_cell.sv @@
// one list slot: holds an entry, compares it, shifts from its right neighbor
`default_nettype none

module cvl_cell import cvl_pkg::*; #(
  parameter int IDX  = 0,
  parameter int CW   = 7,
  parameter int CMPW = 7
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] cmp_value,
  input  logic [CMPW-1:0]          rd_pos,
  input  logic [CW-1:0]            count,
  input  logic signed [DATA_W-1:0] app_value,
  input  logic signed [DATA_W-1:0] next_entry,
  input  logic                     seen_in,
  output logic                     seen_out,
  input  logic signed [DATA_W-1:0] rd_in,
  output logic signed [DATA_W-1:0] rd_out,
  output logic signed [DATA_W-1:0] entry_o
);

  logic signed [DATA_W-1:0] entry_r;
  logic                     match_r;
  logic                     hit_r;
  logic                     occupied;
  logic                     shift_in;

  assign occupied = CW'(IDX) < count;

  // compare stage: local match and read-address hit
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      match_r <= occupied && (entry_r == cmp_value);
      hit_r   <= (rd_pos == CMPW'(IDX));
    end
  end

  // first-match chain: on a remove, every slot at or after the first match shifts
  assign seen_out = seen_in | match_r;
  assign shift_in = ctl.remove && seen_out;

  // update stage: close the gap or take the appended value
  always_ff @(posedge clk) begin
    if (shift_in) begin
      entry_r <= next_entry;
    end else if (ctl.append && (count == CW'(IDX))) begin
      entry_r <= app_value;
    end
  end

  // read-out chain
  assign rd_out  = rd_in | (hit_r ? entry_r : '0);
  assign entry_o = entry_r;

endmodule

`default_nettype wire
